/* design/fssd_pkg.sv */
// ----------------------------------------------------------------------------
// fssd_pkg: shared types and constants of the front scan steering decider
// Holds the decision codes, the register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package fssd_pkg;

  localparam int RANGE_W  = 16;
  localparam int DEC_W    = 2;
  localparam int TURN_W   = 8;
  localparam int CFG_IW   = 1;

  // steering deadband in half degrees
  localparam int TURN_LIMIT = 10;

  localparam logic [DEC_W-1:0] DEC_STOP     = 2'd0;
  localparam logic [DEC_W-1:0] DEC_CONTINUE = 2'd1;
  localparam logic [DEC_W-1:0] DEC_ROTATE   = 2'd2;

  localparam logic [CFG_IW-1:0] REG_STOP_DIST = 1'd0;
  localparam logic [CFG_IW-1:0] REG_SLOW_DIST = 1'd1;

  localparam logic [RANGE_W-1:0] STOP_DIST_RST = 16'd150;
  localparam logic [RANGE_W-1:0] SLOW_DIST_RST = 16'd300;

  typedef struct packed {
    logic take;    // beam request accepted
    logic start;   // last beam accepted, begin window scan
    logic finish;  // latch result, clear scan state
  } fssd_cmd_t;

  typedef struct packed {
    logic scan_done;
  } fssd_stat_t;

endpackage

/* design/fssd_ctrl.sv */
// ----------------------------------------------------------------------------
// fssd_ctrl: sequencing controller
// Loads beams, runs the window scan and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module fssd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_beam,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fssd_pkg::fssd_cmd_t  cmd,
  input  fssd_pkg::fssd_stat_t stat
);
  import fssd_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_LOAD: begin
        in_ready  = 1'b1;
        cmd.take  = in_valid;
        cmd.start = in_valid && in_last_beam;
        if (in_valid && in_last_beam) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output slot to be free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/fssd_dp.sv */
// ----------------------------------------------------------------------------
// fssd_dp: beam store, scan flags and sliding window scorer
// Stores beams, tracks extremes and proximity flags, streams the store
// through a tap line and keeps the first best window.
// ----------------------------------------------------------------------------
module fssd_dp #(
  parameter int BEAMS           = 180,
  parameter int HALF_WINDOW     = 3,
  parameter int SLOW_HALF_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fssd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [fssd_pkg::RANGE_W-1:0]  cfg_wdata,
  input  logic [fssd_pkg::RANGE_W-1:0]  in_range_cm,
  input  fssd_pkg::fssd_cmd_t           cmd,
  output fssd_pkg::fssd_stat_t          stat,
  output logic [fssd_pkg::DEC_W-1:0]    out_decision,
  output logic signed [fssd_pkg::TURN_W-1:0] out_turn_halfdeg
);
  import fssd_pkg::*;

  localparam int AW    = $clog2(BEAMS);
  localparam int CW    = $clog2(BEAMS + 1);
  localparam int WIN   = 2 * HALF_WINDOW;
  localparam int SUM_W = RANGE_W + $clog2(WIN);
  localparam int CEN   = BEAMS / 2;
  localparam int AGW   = (AW + 2 > 9) ? AW + 2 : 9;

  localparam logic [AW-1:0] LAST_A   = AW'(BEAMS - 3);
  localparam logic [AW-1:0] FIRST_K  = AW'(WIN - 1);
  localparam logic signed [AGW-1:0] ZONE_LO = AGW'(CEN - SLOW_HALF_WIDTH);
  localparam logic signed [AGW-1:0] ZONE_HI = AGW'(CEN + SLOW_HALF_WIDTH);

  // configuration
  logic [RANGE_W-1:0] stop_dist_r, slow_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_dist_r <= STOP_DIST_RST;
      slow_dist_r <= SLOW_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STOP_DIST: stop_dist_r <= cfg_wdata;
        REG_SLOW_DIST: slow_dist_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // load side
  logic [RANGE_W-1:0] mem [BEAMS];
  logic [CW-1:0]      cnt_r;
  logic [RANGE_W-1:0] min_r, max_r;
  logic               stop_r, slow_r;
  logic               store_en, in_zone;
  logic signed [AGW-1:0] idx_s;

  assign store_en = cmd.take && (cnt_r < CW'(BEAMS));
  assign idx_s    = $signed({{(AGW-CW){1'b0}}, cnt_r});
  assign in_zone  = (idx_s > ZONE_LO) && (idx_s < ZONE_HI);

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[cnt_r[AW-1:0]] <= in_range_cm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      cnt_r  <= '0;
      min_r  <= '1;
      max_r  <= '0;
      stop_r <= 1'b0;
      slow_r <= 1'b0;
    end else if (store_en) begin
      cnt_r <= cnt_r + 1'b1;
      if (in_range_cm != '0) begin
        if (in_range_cm <= stop_dist_r) begin
          stop_r <= 1'b1;
        end else if (in_range_cm <= slow_dist_r && in_zone) begin
          slow_r <= 1'b1;
        end
        if (in_range_cm > max_r) max_r <= in_range_cm;
        if (in_range_cm < min_r) min_r <= in_range_cm;
      end
    end
  end

  // scan pipeline: issue address, read, accumulate, compare
  logic               iss_r, va_r, vb_r;
  logic [AW-1:0]      a_r, ka_r, kb_r;
  logic [RANGE_W-1:0] rd_r;
  logic               inr_r;
  logic [RANGE_W-1:0] taps_r [WIN];
  logic [RANGE_W-1:0] beam_v;
  logic [SUM_W-1:0]   sum_r, thr_r, best_r;
  logic [AW-1:0]      best_i_r;
  logic               found_r;
  logic               hit;

  always_ff @(posedge clk) begin
    if (iss_r) begin
      rd_r <= mem[a_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        iss_r <= 1'b1;
      end else if (iss_r && a_r == LAST_A) begin
        iss_r <= 1'b0;
      end
      va_r <= iss_r;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= '0;
    end else if (iss_r) begin
      a_r <= a_r + 1'b1;
    end
    ka_r  <= a_r;
    inr_r <= CW'(a_r) < cnt_r;
    kb_r  <= ka_r;
    thr_r <= SUM_W'(min_r) * SUM_W'(WIN);
  end

  // positions not received in this scan read as invalid
  assign beam_v = inr_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum_r <= '0;
      for (int t = 0; t < WIN; t++) begin
        taps_r[t] <= '0;
      end
    end else if (va_r) begin
      sum_r     <= sum_r + SUM_W'(beam_v) - SUM_W'(taps_r[WIN-1]);
      taps_r[0] <= beam_v;
      for (int t = 1; t < WIN; t++) begin
        taps_r[t] <= taps_r[t-1];
      end
    end
  end

  // score beats both the best so far and the minimum-range baseline (WIN times min_r)
  assign hit = vb_r && (kb_r >= FIRST_K) && (sum_r > best_r) && (sum_r > thr_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_r  <= '0;
      found_r <= 1'b0;
    end else if (hit) begin
      best_r   <= sum_r;
      best_i_r <= AW'(kb_r - AW'(HALF_WINDOW - 1));
      found_r  <= 1'b1;
    end
  end

  assign stat.scan_done = !iss_r && !va_r && !vb_r;

  // result
  logic signed [AGW-1:0] ang, ang_sat;
  logic [DEC_W-1:0]      dec_c;
  logic [TURN_W-1:0]     turn_c;
  logic [DEC_W-1:0]      dec_r;
  logic [TURN_W-1:0]     turn_r;

  assign ang = $signed({{(AGW-AW){1'b0}}, best_i_r}) - AGW'(CEN);

  always_comb begin
    ang_sat = ang;
    if (ang > AGW'(127)) begin
      ang_sat = AGW'(127);
    end else if (ang < AGW'(-128)) begin
      ang_sat = AGW'(-128);
    end
  end

  always_comb begin
    priority if (stop_r) begin
      dec_c  = DEC_STOP;
      turn_c = '0;
    end else if (max_r <= min_r || !found_r) begin
      dec_c  = DEC_CONTINUE;
      turn_c = '0;
    end else begin
      if (!slow_r && ang >= AGW'(-TURN_LIMIT) && ang <= AGW'(TURN_LIMIT)) begin
        dec_c = DEC_CONTINUE;
      end else begin
        dec_c = DEC_ROTATE;
      end
      turn_c = ang_sat[TURN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dec_r  <= dec_c;
      turn_r <= turn_c;
    end
  end

  assign out_decision     = dec_r;
  assign out_turn_halfdeg = $signed(turn_r);

endmodule

/* design/front_scan_steering_decider.sv */
// rate: beams load one per cycle while the controller is in its load state; a last beam
//   starts a window scan that reads the beam store through its single read port, and no
//   new beam is accepted until the decision is handed to the output register
// reset: synchronous active-low rst_n clears the controller, scan flags, extremes
//   and beam count and restores stop 150 cm / slow 300 cm; the beam store is not cleared
// ----------------------------------------------------------------------------
// front_scan_steering_decider: steering decision from one front laser scan
// Collects range beams, flags close obstacles, scores six-beam windows
// above the minimum range and emits a stop / continue / rotate decision.
// ----------------------------------------------------------------------------
module front_scan_steering_decider #(
  parameter int BEAMS           = 180,
  parameter int HALF_WINDOW     = 3,
  parameter int SLOW_HALF_WIDTH = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [fssd_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [fssd_pkg::RANGE_W-1:0]       cfg_wdata,
  // beam requests
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fssd_pkg::RANGE_W-1:0]       in_range_cm,
  input  logic                               in_last_beam,
  // decision requests
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fssd_pkg::DEC_W-1:0]         out_decision,
  output logic signed [fssd_pkg::TURN_W-1:0] out_turn_halfdeg
);
  import fssd_pkg::*;

  fssd_cmd_t  cmd;
  fssd_stat_t stat;

  // controller: load, scan, hand off result; a finished decision waits in
  // the output register while the next scan loads
  fssd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_beam (in_last_beam),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // datapath: beam store, flags, sliding window sum and best tracker
  fssd_dp #(
    .BEAMS           (BEAMS),
    .HALF_WINDOW     (HALF_WINDOW),
    .SLOW_HALF_WIDTH (SLOW_HALF_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_range_cm      (in_range_cm),
    .cmd              (cmd),
    .stat             (stat),
    .out_decision     (out_decision),
    .out_turn_halfdeg (out_turn_halfdeg)
  );

endmodule

/* design/fssd_chk.sv */
// ----------------------------------------------------------------------------
// fssd_chk: port-level checks of the steering decider
// Watches the result channel and the scan handoff over time.
// ----------------------------------------------------------------------------
module fssd_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_last_beam,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [fssd_pkg::DEC_W-1:0]         out_decision,
  input logic signed [fssd_pkg::TURN_W-1:0] out_turn_halfdeg
);
  import fssd_pkg::*;

  // a stalled decision holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_decision)
      && $stable(out_turn_halfdeg))
    else $error("stalled decision changed");

  // stop always carries a zero angle
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decision == DEC_STOP |-> out_turn_halfdeg == '0)
    else $error("stop with nonzero angle");

  // continue only inside the deadband
  a_cont_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decision == DEC_CONTINUE |->
      out_turn_halfdeg >= TURN_W'(-TURN_LIMIT) && out_turn_halfdeg <= TURN_W'(TURN_LIMIT))
    else $error("continue outside deadband");

  // a last beam hands over to the scan, no beam accepted next cycle
  a_scan_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_beam |=> !in_ready)
    else $error("beam accepted right after last beam");

endmodule

bind front_scan_steering_decider fssd_chk u_fssd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last_beam     (in_last_beam),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_decision     (out_decision),
  .out_turn_halfdeg (out_turn_halfdeg)
);

/* tb/front_scan_steering_decider_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// front_scan_steering_decider_tb: self-checking bench of the steering decider
// Streams scans of beam ranges through the input handshake, predicts each
// stop / continue / rotate decision from its own scan model and compares
// every decision request against the oldest prediction.
// ----------------------------------------------------------------------------
module front_scan_steering_decider_tb;
  import fssd_pkg::*;

  localparam int BEAMS     = 180;
  localparam int HALF_WIN  = 3;
  localparam int SLOW_HALF = 20;
  // settle time for the window scan to drain after the last beam
  localparam int SETTLE_CYCLES = BEAMS + 16;

  typedef struct packed {
    logic [RANGE_W-1:0] range_cm;
    logic               last_beam;
  } beam_req_t;

  typedef struct packed {
    logic [DEC_W-1:0]         decision;
    logic signed [TURN_W-1:0] turn_halfdeg;
  } verdict_t;

  typedef enum int {SCAN_CLEAR, SCAN_SLOW, SCAN_BLOCKED, SCAN_NOISE, SCAN_FLAT} scan_kind_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IW-1:0]          cfg_index = '0;
  logic [RANGE_W-1:0]         cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [RANGE_W-1:0]         in_range_cm = '0;
  logic                       in_last_beam = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [DEC_W-1:0]           out_decision;
  logic signed [TURN_W-1:0]   out_turn_halfdeg;

  // pending beam requests and predicted decisions
  beam_req_t beam_req_q[$];
  verdict_t  verdict_q[$];
  beam_req_t next_req;
  verdict_t  want;

  int send_idle_pct = 6;
  int recv_idle_pct = 54;
  int fail_count = 0;

  // scan model: configuration copy and per-scan state
  logic [RANGE_W-1:0] stop_dist_cm = STOP_DIST_RST;
  logic [RANGE_W-1:0] slow_dist_cm = SLOW_DIST_RST;
  logic [RANGE_W-1:0] scan_beams [BEAMS];
  int                 scan_len = 0;
  logic [RANGE_W-1:0] scan_min = '1;
  logic [RANGE_W-1:0] scan_max = '0;
  logic               scan_stop = 1'b0;
  logic               scan_slow = 1'b0;

  front_scan_steering_decider #(
    .BEAMS(BEAMS),
    .HALF_WINDOW(HALF_WIN),
    .SLOW_HALF_WIDTH(SLOW_HALF)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_range_cm(in_range_cm),
    .in_last_beam(in_last_beam),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_decision(out_decision),
    .out_turn_halfdeg(out_turn_halfdeg)
  );

  always #5 clk = ~clk;

  // fold one accepted beam into the scan; on the last beam predict the decision
  function automatic void absorb_beam(input logic [RANGE_W-1:0] r, input logic last_flag);
    longint   score;
    longint   best;
    int       c;
    int       j;
    int       best_c;
    int       angle;
    int       idx;
    verdict_t v;
    // beams past the end of the beam store are dropped, but a last flag still counts
    if (scan_len < BEAMS) begin
      idx = scan_len;
      scan_beams[idx] = r;
      scan_len++;
      if (r != '0) begin
        if (r <= stop_dist_cm) begin
          scan_stop = 1'b1;
        end else if (r <= slow_dist_cm && idx > BEAMS / 2 - SLOW_HALF &&
                     idx < BEAMS / 2 + SLOW_HALF) begin
          scan_slow = 1'b1;
        end
        if (r > scan_max) scan_max = r;
        if (r < scan_min) scan_min = r;
      end
    end
    if (!last_flag) return;
    v.decision = DEC_CONTINUE;
    v.turn_halfdeg = '0;
    best = 0;
    best_c = 0;
    if (scan_stop) begin
      v.decision = DEC_STOP;
    end else if (scan_max > scan_min) begin
      // first strictly best window, unreceived beams count as range zero
      for (c = HALF_WIN; c < BEAMS - HALF_WIN - 1; c++) begin
        score = 0;
        for (j = c - HALF_WIN; j < c + HALF_WIN; j++) begin
          score += ((j < scan_len) ? longint'(scan_beams[j]) : 64'sd0) - longint'(scan_min);
        end
        if (score > best) begin
          best = score;
          best_c = c;
        end
      end
      // no positive window leaves continue straight ahead
      if (best_c != 0) begin
        angle = best_c - BEAMS / 2;
        if (scan_slow || angle < -TURN_LIMIT || angle > TURN_LIMIT) v.decision = DEC_ROTATE;
        if (angle > 127) angle = 127;
        else if (angle < -128) angle = -128;
        v.turn_halfdeg = angle[TURN_W-1:0];
      end
    end
    verdict_q.insert(verdict_q.size(), v);
    scan_len = 0;
    scan_min = '1;
    scan_max = '0;
    scan_stop = 1'b0;
    scan_slow = 1'b0;
  endfunction

  // driver: hold a request until taken, random gaps between requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_beam(in_range_cm, in_last_beam);
      if (!in_valid || in_ready) begin
        if (beam_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = beam_req_q.pop_front();
          in_valid <= 1'b1;
          in_range_cm <= next_req.range_cm;
          in_last_beam <= next_req.last_beam;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, check each decision request in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected decision: expected none, actual %0d / %0d",
                   $time, out_decision, out_turn_halfdeg);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_decision !== want.decision) begin
            $display("%0t decision mismatch: expected %0d, actual %0d",
                     $time, want.decision, out_decision);
            fail_count++;
          end
          if (out_turn_halfdeg !== want.turn_halfdeg) begin
            $display("%0t turn mismatch: expected %0d, actual %0d",
                     $time, want.turn_halfdeg, out_turn_halfdeg);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_beam(input logic [RANGE_W-1:0] r, input logic last_flag);
    beam_req_t req;
    req.range_cm = r;
    req.last_beam = last_flag;
    beam_req_q.insert(beam_req_q.size(), req);
  endtask

  // range of beam k for a given scan flavor
  function automatic logic [RANGE_W-1:0] pick_range(input scan_kind_t kind, input int k,
                                                    input int peak, input int width,
                                                    input int hit,
                                                    input logic [RANGE_W-1:0] flat_cm);
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    int unsigned slow_lo;
    if (kind == SCAN_FLAT) return ($urandom_range(9) == 0) ? '0 : flat_cm;
    if (kind == SCAN_NOISE) begin
      case ($urandom_range(9))
        0: return '0;
        1: return '1;
        default: return RANGE_W'($urandom_range(65535));
      endcase
    end
    if (kind == SCAN_BLOCKED && k == hit) begin
      if (stop_dist_cm == '0) return '0;
      return $urandom_range(1) ? stop_dist_cm : RANGE_W'($urandom_range(1, stop_dist_cm));
    end
    // scattered invalid beams
    if ($urandom_range(19) == 0) return '0;
    slow_lo = stop_dist_cm;
    slow_lo = slow_lo + 1;
    if (kind == SCAN_SLOW && k > BEAMS / 2 - SLOW_HALF && k < BEAMS / 2 + SLOW_HALF &&
        slow_dist_cm > stop_dist_cm && $urandom_range(7) == 0) begin
      return RANGE_W'($urandom_range(slow_lo, slow_dist_cm));
    end
    // free space just beyond both thresholds, with an opening around the peak
    lo = (stop_dist_cm > slow_dist_cm) ? stop_dist_cm : slow_dist_cm;
    lo = (lo < 65535) ? lo + 1 : 65535;
    hi = (lo + 2000 < 65535) ? lo + 2000 : 65535;
    v = ($urandom_range(9) == 0) ? lo : $urandom_range(lo, hi);
    if (k >= peak - width && k <= peak + width) v += $urandom_range(500, 20000);
    return (v > 65535) ? '1 : RANGE_W'(v);
  endfunction

  task automatic queue_scan(input int n_beams, input scan_kind_t kind);
    int                 k;
    int                 peak;
    int                 width;
    int                 hit;
    logic [RANGE_W-1:0] flat_cm;
    // openings near the center give small turns, often continue
    peak = ($urandom_range(99) < 45) ? $urandom_range(78, 102) : $urandom_range(0, BEAMS - 1);
    width = $urandom_range(0, 8);
    hit = $urandom_range(0, ((n_beams < BEAMS) ? n_beams : BEAMS) - 1);
    flat_cm = ($urandom_range(3) == 0) ? '1 : RANGE_W'($urandom_range(1, 65535));
    for (k = 0; k < n_beams; k++) begin
      queue_beam(pick_range(kind, k, peak, width, hit, flat_cm), k == n_beams - 1);
    end
  endtask

  // only while idle: no request pending, nothing predicted, scan engine drained
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_quiet();
    while (beam_req_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [RANGE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STOP_DIST) stop_dist_cm = val;
    else slow_dist_cm = val;
  endtask

  initial begin
    int          phase;
    int          items;
    int          scans;
    int          len;
    int          pick;
    int unsigned stop_v;
    int unsigned slow_v;
    scan_kind_t  kind;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed scans at reset thresholds (stop 150, slow 300)
    queue_beam(16'd0, 1'b1);                 // no valid beam
    queue_beam(16'hFFFF, 1'b1);              // single valid beam, all equal
    queue_beam(16'd1000, 1'b0);              // every window scores negative
    queue_beam(16'd0, 1'b0);
    queue_beam(16'd2000, 1'b1);
    queue_beam(16'd151, 1'b0);               // one above stop, then exactly at stop
    queue_beam(16'd150, 1'b1);
    queue_beam(16'd0, 1'b0);                 // short scan, opening far right: rotate
    queue_beam(16'd0, 1'b0);
    queue_beam(16'd0, 1'b0);
    queue_beam(16'hFFFF, 1'b0);
    queue_beam(16'd5000, 1'b0);
    queue_beam(16'hFFFF, 1'b0);
    queue_beam(16'd5000, 1'b0);
    queue_beam(16'hFFFF, 1'b0);
    queue_beam(16'd5000, 1'b0);
    queue_beam(16'd200, 1'b1);
    queue_beam(16'd301, 1'b0);               // smallest range forces stop
    queue_beam(16'd1, 1'b1);

    for (phase = 0; phase < 6; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          stop_v = $urandom_range(50, 400);
          slow_v = stop_v + $urandom_range(0, 600);
        end
        1: begin
          stop_v = 0;
          slow_v = 65535;
        end
        2: begin
          stop_v = 65535;
          slow_v = 0;
        end
        3: begin
          stop_v = $urandom_range(500, 3000);
          slow_v = $urandom_range(0, stop_v);
        end
        4: begin
          stop_v = $urandom_range(65535);
          slow_v = $urandom_range(65535);
        end
        default: begin
          stop_v = STOP_DIST_RST;
          slow_v = SLOW_DIST_RST;
        end
      endcase
      write_reg(REG_STOP_DIST, RANGE_W'(stop_v));
      write_reg(REG_SLOW_DIST, RANGE_W'(slow_v));
      // slow receiver first, then slow sender, then full speed
      send_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 54 : 0;
      recv_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 6 : 0;

      items = 0;
      scans = 0;
      while (items < 270 || scans < 3) begin
        pick = $urandom_range(99);
        if (pick < 22) len = BEAMS;
        else if (pick < 32) len = BEAMS + $urandom_range(1, 24);
        else if (pick < 62) len = $urandom_range(1, 12);
        else len = $urandom_range(13, BEAMS - 1);
        pick = $urandom_range(99);
        if (pick < 40) kind = SCAN_CLEAR;
        else if (pick < 60) kind = SCAN_SLOW;
        else if (pick < 75) kind = SCAN_BLOCKED;
        else if (pick < 90) kind = SCAN_NOISE;
        else kind = SCAN_FLAT;
        queue_scan(len, kind);
        items += len;
        scans++;
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
